// ----- src/asc_pkg.sv -----
// Shared types, constants and elaboration-time functions for the step-size controller.
package asc_pkg;

  localparam int unsigned SUM_W = 44;
  localparam int unsigned SQ_W = 32;
  localparam int unsigned LOG_W = 22;
  localparam int unsigned ACC_W = 26;
  localparam int unsigned MANT_W = 31;
  localparam int unsigned FRAC_N = 16;

  localparam logic [15:0] MIN_S_Q14 = 16'd6554;
  localparam logic [15:0] MAX_S_Q14 = 16'd40960;
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  typedef enum logic [1:0] {
    DEC_SHRINK = 2'd0,
    DEC_KEEP   = 2'd1,
    DEC_GROW   = 2'd2
  } decision_t;

  typedef enum logic [2:0] {
    CFG_SAFETY    = 3'd0,
    CFG_ORDER     = 3'd1,
    CFG_TOLERANCE = 3'd2,
    CFG_INC_THR   = 3'd3,
    CFG_DEC_THR   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] safety_factor;
    logic [3:0]  error_order;
    logic [31:0] relative_tolerance;
    logic [15:0] increment_threshold;
    logic [13:0] decrement_threshold;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] err_sum;
    logic [SUM_W-1:0] sol_sum;
  } sums_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Factor 2^(2^-k) in Q1.30 for k = 1..16.
  function automatic logic [MANT_W-1:0] exp2_coef(input int k);
    logic [63:0] c;
    c = isqrt64(64'd2 << 60);
    for (int j = 1; j < 17; j++) begin
      if (j < k) begin
        c = isqrt64(c << 30);
      end
    end
    return c[MANT_W-1:0];
  endfunction

endpackage

// ----- src/asc_in_if.sv -----
// Input sample channel.
interface asc_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] err_real;
  logic signed [15:0] err_imag;
  logic signed [15:0] sol_real;
  logic signed [15:0] sol_imag;
  logic              last_sample;
  modport source(output valid, err_real, err_imag, sol_real, sol_imag, last_sample,
                 input ready);
  modport sink(input valid, err_real, err_imag, sol_real, sol_imag, last_sample,
               output ready);
endinterface

// ----- src/asc_out_if.sv -----
// Result channel.
interface asc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] scale_factor;
  logic [1:0]  decision;
  modport source(output valid, scale_factor, decision, input ready);
  modport sink(input valid, scale_factor, decision, output ready);
endinterface

// ----- src/asc_cfg_if.sv -----
// Configuration write channel.
interface asc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  idx;
  logic [31:0] data;
  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

// ----- src/asc_front.sv -----
// Front end: squares samples and accumulates saturating sums per vector.
module asc_front (
  input  logic            clk,
  input  logic            rst_n,
  asc_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output asc_pkg::sums_t  push_data
);

  logic                       s1_v_r;
  logic                       s1_last_r;
  logic [asc_pkg::SQ_W-1:0]   esq_r;
  logic [asc_pkg::SQ_W-1:0]   ssq_r;
  logic [asc_pkg::SUM_W-1:0]  esum_r;
  logic [asc_pkg::SUM_W-1:0]  ssum_r;
  logic signed [31:0]         er2, ei2, sr2, si2;
  logic [asc_pkg::SUM_W:0]    esum_w, ssum_w;
  logic [asc_pkg::SUM_W-1:0]  esum_nxt, ssum_nxt;
  logic                       adv;

  assign adv = !s1_v_r || !s1_last_r || !q_full;
  assign in_ch.ready = adv;

  assign er2 = in_ch.err_real * in_ch.err_real;
  assign ei2 = in_ch.err_imag * in_ch.err_imag;
  assign sr2 = in_ch.sol_real * in_ch.sol_real;
  assign si2 = in_ch.sol_imag * in_ch.sol_imag;

  assign esum_w = {1'b0, esum_r} + {13'd0, esq_r};
  assign ssum_w = {1'b0, ssum_r} + {13'd0, ssq_r};
  assign esum_nxt = esum_w[asc_pkg::SUM_W] ? '1 : esum_w[asc_pkg::SUM_W-1:0];
  assign ssum_nxt = ssum_w[asc_pkg::SUM_W] ? '1 : ssum_w[asc_pkg::SUM_W-1:0];

  assign push = s1_v_r && s1_last_r && adv;
  assign push_data.err_sum = esum_nxt;
  assign push_data.sol_sum = ssum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s1_last_r <= 1'b0;
      esum_r <= '0;
      ssum_r <= '0;
    end else begin
      if (s1_v_r && adv) begin
        if (s1_last_r) begin
          esum_r <= '0;
          ssum_r <= '0;
        end else begin
          esum_r <= esum_nxt;
          ssum_r <= ssum_nxt;
        end
      end
      if (in_ch.valid && adv) begin
        s1_v_r <= 1'b1;
        s1_last_r <= in_ch.last_sample;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && adv) begin
      esq_r <= $unsigned(er2) + $unsigned(ei2);
      ssq_r <= $unsigned(sr2) + $unsigned(si2);
    end
  end

endmodule

// ----- src/asc_queue.sv -----
// Two-entry queue of finished vector sums between front and back.
module asc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  asc_pkg::sums_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output asc_pkg::sums_t head
);

  asc_pkg::sums_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

// ----- src/asc_back.sv -----
// Back end: log2, serial divide, exp2 and clamping per vector, with output register.
module asc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  asc_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  asc_pkg::sums_t head,
  output logic           pop,
  asc_out_if.source      out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_LOGI, S_LOGS, S_DIVI, S_DIVS, S_EXPI, S_EXPS, S_SHF, S_FIN
  } state_t;

  state_t                       state_r;
  logic [asc_pkg::SUM_W-1:0]    e_r, y_r;
  logic                         ezero_r;
  logic [1:0]                   idx_r;
  logic [4:0]                   cnt_r;
  logic [5:0]                   p_r;
  logic [asc_pkg::MANT_W-1:0]   m_r;
  logic [15:0]                  frac_r;
  logic signed [asc_pkg::ACC_W-1:0] lacc_r, l_r;
  logic [asc_pkg::LOG_W-1:0]    ls_r;
  logic [24:0]                  mag_r, quo_r;
  logic [4:0]                   rem_r;
  logic                         neg_r;
  logic [31:0]                  s30_r;
  logic                         out_v_r;
  logic [15:0]                  out_sf_r;
  logic [1:0]                   out_dec_r;

  logic [asc_pkg::MANT_W-1:0]   coef [16];
  logic [asc_pkg::MANT_W-1:0]   mul_a, mul_b;
  logic [2*asc_pkg::MANT_W-1:0] prod;
  logic [asc_pkg::SUM_W-1:0]    op;
  logic [5:0]                   msb;
  logic [asc_pkg::SUM_W-1:0]    norm;
  logic [31:0]                  sq;
  logic [asc_pkg::LOG_W-1:0]    lval;
  logic signed [asc_pkg::ACC_W-1:0] n_val, fd, l_nxt;
  logic [4:0]                   dvs;
  logic [5:0]                   rem_sh;
  logic signed [9:0]            ip;
  logic [32:0]                  v_lo, v_hi;
  logic [15:0]                  res;

  for (genvar g = 0; g < 16; g++) begin : g_coef
    assign coef[g] = asc_pkg::exp2_coef(g + 1);
  end

  assign mul_a = (state_r == S_EXPS) ? m_r : m_r;
  assign mul_b = (state_r == S_EXPS) ? coef[cnt_r[3:0]] : m_r;
  assign prod = mul_a * mul_b;

  always_comb begin
    case (idx_r)
      2'd0: op = {12'd0, cfg.relative_tolerance};
      2'd1: op = y_r;
      2'd2: op = e_r;
      default: op = {28'd0, cfg.safety_factor};
    endcase
  end

  always_comb begin
    msb = 6'd0;
    for (int i = 0; i < asc_pkg::SUM_W; i++) begin
      if (op[i]) msb = 6'(i);
    end
  end

  assign norm = (msb <= 6'd30) ? (op << (6'd30 - msb)) : (op >> (msb - 6'd30));
  assign sq = prod[61:30];
  assign lval = {p_r, frac_r};

  assign n_val = lacc_r - 26'sd4194304;
  assign dvs = (cfg.error_order == 4'd0) ? 5'd2 : {cfg.error_order, 1'b0};
  assign rem_sh = {rem_r, mag_r[24]};
  assign fd = neg_r ? -$signed({1'b0, quo_r} + {25'd0, (rem_r != 5'd0)})
                    : $signed({1'b0, quo_r});
  assign l_nxt = fd + $signed({4'd0, ls_r}) - 26'sd1048576;
  assign ip = l_r[25:16];

  always_comb begin
    v_lo = {1'b0, s30_r};
    if (v_lo < {1'b0, asc_pkg::MIN_S_Q14, 16'd0}) v_lo = {1'b0, asc_pkg::MIN_S_Q14, 16'd0};
    if (v_lo > {3'd0, cfg.decrement_threshold, 16'd0}) v_lo = {3'd0, cfg.decrement_threshold, 16'd0};
    v_hi = {1'b0, s30_r};
    if (v_hi > {1'b0, asc_pkg::MAX_S_Q14, 16'd0}) v_hi = {1'b0, asc_pkg::MAX_S_Q14, 16'd0};
    if (ezero_r) begin
      res = asc_pkg::MIN_S_Q14;
    end else if (s30_r < 32'h4000_0000) begin
      res = v_lo[31:16];
    end else if (v_hi < {1'b0, cfg.increment_threshold, 16'd0}) begin
      res = asc_pkg::ONE_Q14;
    end else begin
      res = v_hi[31:16];
    end
  end

  assign pop = (state_r == S_IDLE) && !q_empty && !out_v_r;

  assign out_ch.valid = out_v_r;
  assign out_ch.scale_factor = out_sf_r;
  assign out_ch.decision = out_dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            e_r <= head.err_sum;
            y_r <= head.sol_sum;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          ezero_r <= (e_r == '0);
          s30_r <= '0;
          idx_r <= 2'd0;
          lacc_r <= '0;
          if (e_r == '0 || y_r == '0 || cfg.relative_tolerance == '0 ||
              cfg.safety_factor == '0) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_LOGI;
          end
        end
        S_LOGI: begin
          p_r <= msb;
          m_r <= norm[asc_pkg::MANT_W-1:0];
          frac_r <= '0;
          cnt_r <= '0;
          state_r <= S_LOGS;
        end
        S_LOGS: begin
          if (sq[31]) m_r <= sq[31:1];
          else m_r <= sq[30:0];
          frac_r <= {frac_r[14:0], sq[31]};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd16) begin
            cnt_r <= '0;
            m_r <= m_r;
            frac_r <= frac_r;
            case (idx_r)
              2'd0: lacc_r <= lacc_r + $signed({3'd0, lval, 1'b0});
              2'd1: lacc_r <= lacc_r + $signed({4'd0, lval});
              2'd2: lacc_r <= lacc_r - $signed({4'd0, lval});
              default: ls_r <= lval;
            endcase
            idx_r <= idx_r + 2'd1;
            state_r <= (idx_r == 2'd3) ? S_DIVI : S_LOGI;
          end
        end
        S_DIVI: begin
          neg_r <= n_val[25];
          mag_r <= n_val[25] ? 25'(-n_val) : n_val[24:0];
          quo_r <= '0;
          rem_r <= '0;
          cnt_r <= '0;
          state_r <= S_DIVS;
        end
        S_DIVS: begin
          if (rem_sh >= {1'b0, dvs}) begin
            rem_r <= 5'(rem_sh - {1'b0, dvs});
            quo_r <= {quo_r[23:0], 1'b1};
          end else begin
            rem_r <= rem_sh[4:0];
            quo_r <= {quo_r[23:0], 1'b0};
          end
          mag_r <= {mag_r[23:0], 1'b0};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd24) state_r <= S_EXPI;
        end
        S_EXPI: begin
          l_r <= l_nxt;
          m_r <= 31'd1 << 30;
          cnt_r <= '0;
          state_r <= S_EXPS;
        end
        S_EXPS: begin
          if (!ip[9] && ip >= 10'sd2) begin
            s30_r <= {asc_pkg::MAX_S_Q14, 16'd0};
            state_r <= S_FIN;
          end else if (ip < -10'sd40) begin
            s30_r <= '0;
            state_r <= S_FIN;
          end else begin
            if (l_r[4'd15 - cnt_r[3:0]]) m_r <= prod[60:30];
            cnt_r <= cnt_r + 5'd1;
            if (cnt_r == 5'd15) state_r <= S_SHF;
          end
        end
        S_SHF: begin
          if (ip[9]) s30_r <= {1'b0, m_r} >> 6'(-ip);
          else s30_r <= {1'b0, m_r} << ip[0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_v_r <= 1'b1;
          out_sf_r <= res;
          if (res < asc_pkg::ONE_Q14) out_dec_r <= asc_pkg::DEC_SHRINK;
          else if (res == asc_pkg::ONE_Q14) out_dec_r <= asc_pkg::DEC_KEEP;
          else out_dec_r <= asc_pkg::DEC_GROW;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/adaptive_step_size_controller_top.sv -----
// Top level of the adaptive step-size controller.
// Throughput: one sample per cycle; the front stalls only with two finished vectors queued,
// and the back takes the next vector only after its previous result has been accepted.
// Sequence: per vector the back runs four log2 passes and exp2 on the shared 31x31 multiplier,
// with a serial divide between them; zero sums skip straight to the result.
// Reset: synchronous active-low rst_n clears sums, queue, sequencer and loads default registers.
module adaptive_step_size_controller_top (
  input  logic     clk,
  input  logic     rst_n,
  asc_in_if.sink   in_ch,
  asc_out_if.source out_ch,
  asc_cfg_if.sink  cfg_ch
);

  asc_pkg::cfg_t  cfg_r;
  asc_pkg::sums_t push_data, head;
  logic           push, q_full, q_empty, pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.safety_factor <= 16'd58982;
      cfg_r.error_order <= 4'd5;
      cfg_r.relative_tolerance <= 32'd4294967;
      cfg_r.increment_threshold <= 16'd20480;
      cfg_r.decrement_threshold <= 14'd13926;
    end else if (cfg_ch.valid) begin
      case (asc_pkg::cfg_idx_t'(cfg_ch.idx))
        asc_pkg::CFG_SAFETY:    cfg_r.safety_factor <= cfg_ch.data[15:0];
        asc_pkg::CFG_ORDER:     cfg_r.error_order <= cfg_ch.data[3:0];
        asc_pkg::CFG_TOLERANCE: cfg_r.relative_tolerance <= cfg_ch.data;
        asc_pkg::CFG_INC_THR:   cfg_r.increment_threshold <= cfg_ch.data[15:0];
        asc_pkg::CFG_DEC_THR:   cfg_r.decrement_threshold <= cfg_ch.data[13:0];
        default: ;
      endcase
    end
  end

  asc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_full(q_full), .push(push), .push_data(push_data)
  );

  asc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .empty(q_empty), .head(head)
  );

  asc_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_empty(q_empty), .head(head),
    .pop(pop), .out_ch(out_ch)
  );

endmodule

// ----- src/asc_checker.sv -----
// Port-level assertions for the step-size controller, bound to the top level.
module asc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_scale_factor,
  input logic [1:0]  out_decision
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_scale_factor) && $stable(out_decision))
    else $error("result changed under stall");

  a_decision: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_scale_factor < asc_pkg::ONE_Q14 && out_decision == asc_pkg::DEC_SHRINK) ||
      (out_scale_factor == asc_pkg::ONE_Q14 && out_decision == asc_pkg::DEC_KEEP) ||
      (out_scale_factor > asc_pkg::ONE_Q14 && out_decision == asc_pkg::DEC_GROW))
    else $error("decision does not match scale factor");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_scale_factor <= asc_pkg::MAX_S_Q14)
    else $error("scale factor above growth cap");

endmodule

bind adaptive_step_size_controller_top asc_checker u_asc_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_scale_factor(out_ch.scale_factor), .out_decision(out_ch.decision)
);
